// ===== rtl/mecanum_odometry_integrator_top_assert.svh =====
// Assertion macros shared by the odometry integrator RTL.
`ifndef MECANUM_ODOMETRY_INTEGRATOR_TOP_ASSERT_SVH
`define MECANUM_ODOMETRY_INTEGRATOR_TOP_ASSERT_SVH

// Implication checked in the same cycle.
`define MOI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define MOI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/moi_pkg.sv =====
`default_nettype none

package moi_pkg;

    localparam int OPW   = 34;   // multiplier operand width
    localparam int PRODW = 68;   // multiplier product width
    localparam int DEN_W = 19;   // divider input divisor width
    localparam int ATAN_ENTRIES = 30;

    localparam logic signed [OPW-1:0] TURN_PER_RAD = 34'sd683565276;
    localparam logic signed [OPW-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [OPW-1:0] VEL_SCALE    = 34'sd1000;

    typedef enum logic [3:0] {
        REG_WHEEL_RADIUS = 4'd0,
        REG_HALF_SUM     = 4'd1,
        REG_RAD_PER_CNT  = 4'd2,
        REG_PERIOD_MS    = 4'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_PHI0 = 4'd0,
        OP_PHI1 = 4'd1,
        OP_PHI2 = 4'd2,
        OP_PHI3 = 4'd3,
        OP_SX   = 4'd4,
        OP_SY   = 4'd5,
        OP_ST   = 4'd6,
        OP_DBIN = 4'd7,
        OP_ROT0 = 4'd8,
        OP_ROT1 = 4'd9,
        OP_ROT2 = 4'd10,
        OP_ROT3 = 4'd11,
        OP_VX   = 4'd12,
        OP_VY   = 4'd13,
        OP_VW   = 4'd14
    } op_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ISSUE  = 6'b000010,
        ST_WB     = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_CORDIC = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [63:0]      mag;
        logic [DEN_W-1:0] den;
    } div_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [PRODW-1:0] v);
        logic fits;
        fits = (&v[PRODW-1:31]) || !(|v[PRODW-1:31]);
        if (fits)
            return v[31:0];
        else if (v[PRODW-1])
            return 32'sh8000_0000;
        else
            return 32'sh7FFF_FFFF;
    endfunction

    // Round half up, then floor shift.
    function automatic logic signed [PRODW-1:0] rshift(input logic signed [PRODW-1:0] v,
                                                       input int unsigned s);
        logic signed [PRODW-1:0] half;
        half = 68'sd1 <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/moi_mult.sv =====
`default_nettype none

module moi_mult
    import moi_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic signed [OPW-1:0]   a,
    input  wire logic signed [OPW-1:0]   b,
    output logic signed [PRODW-1:0]      prod
);

    logic signed [PRODW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/moi_div.sv =====
`default_nettype none

// Rounded signed division: q = (2|n| + d) / (2d), one quotient bit per cycle.
module moi_div
    import moi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire div_req_t           req,
    output logic                    done,
    output logic signed [31:0]      result
);

    localparam int QB = 31;
    localparam int RW = DEN_W + 1;

    logic [63:0]   num;
    logic [RW-1:0] den;
    logic [63:0]   den_top;

    logic          busy_reg;
    logic          done_reg;
    logic [4:0]    cnt_reg;
    logic          sat_reg;
    logic          neg_reg;
    logic [RW-1:0] den_reg;
    logic [RW-1:0] rem_reg;
    logic [QB-1:0] quo_reg;

    logic [RW:0]   trial_in;
    logic [RW:0]   trial;

    assign num     = {req.mag[62:0], 1'b0} + {{(64-DEN_W){1'b0}}, req.den};
    assign den     = {req.den, 1'b0};
    assign den_top = {{(64-RW){1'b0}}, den} << QB;

    assign trial_in = {rem_reg, quo_reg[QB-1]};
    assign trial    = trial_in - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 5'(QB - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(QB - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            sat_reg <= (num >= den_top);
            neg_reg <= req.neg;
            den_reg <= den;
            // When the quotient fits, the upper part is already below the divisor.
            rem_reg <= num[QB+RW-1:QB];
            quo_reg <= num[QB-1:0];
        end
        else if (busy_reg)
        begin
            if (!trial[RW])
            begin
                rem_reg <= trial[RW-1:0];
                quo_reg <= {quo_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial_in[RW-1:0];
                quo_reg <= {quo_reg[QB-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (sat_reg)
            result = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (neg_reg)
            result = -$signed({1'b0, quo_reg});
        else
            result = $signed({1'b0, quo_reg});
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/moi_cordic.sv =====
`default_nettype none

// Rotation-mode CORDIC giving cos and sin of a binary angle in Q2.30.
module moi_cordic
    import moi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [31:0]           angle,
    output logic                       done,
    output logic signed [OPW-1:0]      cos_val,
    output logic signed [OPW-1:0]      sin_val
);

    localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    logic                 busy_reg;
    logic                 done_reg;
    logic [4:0]           cnt_reg;
    logic                 flip_reg;
    logic signed [OPW-1:0] x_reg;
    logic signed [OPW-1:0] y_reg;
    logic signed [OPW-1:0] z_reg;

    logic                 flip;
    logic [31:0]          a_start;
    logic signed [OPW-1:0] xs;
    logic signed [OPW-1:0] ys;
    logic signed [OPW-1:0] at;

    // Angles in the left half plane are turned by half a turn first.
    assign flip    = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
    assign a_start = flip ? (angle + 32'h8000_0000) : angle;

    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign at = $signed({2'b00, atan_entry(cnt_reg)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 5'(STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            flip_reg <= flip;
            x_reg    <= CORDIC_START;
            y_reg    <= '0;
            z_reg    <= {{(OPW-32){a_start[31]}}, a_start};
        end
        else if (busy_reg)
        begin
            if (!z_reg[OPW-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign cos_val = flip_reg ? -x_reg : x_reg;
    assign sin_val = flip_reg ? -y_reg : y_reg;
    assign done    = done_reg;

endmodule

`default_nettype wire

// ===== rtl/mecanum_odometry_integrator_top.sv =====
`default_nettype none

// Mecanum wheel odometry integrator. One transaction on the input side carries the four
// encoder counts of a sample period; the block answers with one transaction holding the
// updated pose (Q16.16 metres, heading as a 32-bit binary angle) and the body velocities.
// A sequencer runs every product through one shared multiplier (an issue state and a
// write-back state per product, fifteen products), every rounded division through one
// bit-serial divider (four divisions) and the heading through an iterative CORDIC (one
// step per cycle). in_stall is high from acceptance until the result has been moved to
// the output register; the next item can be taken while that result still waits.
// Configuration registers are written through cfg_write, cfg_index and cfg_data. The
// user must write them only while the block is idle; the block itself does not enforce
// this. Indexes above 3 are ignored.
module mecanum_odometry_integrator_top
    import moi_pkg::*;
#(
    parameter int COUNT_BITS   = 16,
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         cfg_write,
    input  wire logic [3:0]                   cfg_index,
    input  wire logic [31:0]                  cfg_data,

    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [COUNT_BITS-1:0] count_front_right,
    input  wire logic signed [COUNT_BITS-1:0] count_front_left,
    input  wire logic signed [COUNT_BITS-1:0] count_rear_left,
    input  wire logic signed [COUNT_BITS-1:0] count_rear_right,

    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [31:0]                position_x,
    output logic signed [31:0]                position_y,
    output logic [31:0]                       heading_angle,
    output logic signed [31:0]                velocity_x,
    output logic signed [31:0]                velocity_y,
    output logic signed [31:0]                velocity_angular
);

    localparam int PHI_SH = 32 - FRAC_BITS;
    localparam int EXT    = OPW - COUNT_BITS;

    // Configuration
    logic [15:0] wheel_radius_reg;
    logic [16:0] half_sum_reg;
    logic [31:0] rad_per_cnt_reg;
    logic [9:0]  period_ms_reg;

    // Control
    state_t state_reg;
    state_t state_next;
    op_t    op_reg;
    op_t    op_next;
    logic   out_valid_reg;

    // Datapath
    logic signed [COUNT_BITS-1:0] cnt_reg [4];
    logic signed [31:0] phi_reg [4];
    logic signed [31:0] dxb_reg;
    logic signed [31:0] dyb_reg;
    logic signed [31:0] dth_reg;
    logic [31:0]        dbin_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] vx_reg;
    logic signed [31:0] vy_reg;
    logic signed [31:0] vw_reg;
    logic signed [31:0] pose_x_reg;
    logic signed [31:0] pose_y_reg;
    logic [31:0]        pose_h_reg;

    logic signed [31:0] position_x_reg;
    logic signed [31:0] position_y_reg;
    logic [31:0]        heading_angle_reg;
    logic signed [31:0] velocity_x_reg;
    logic signed [31:0] velocity_y_reg;
    logic signed [31:0] velocity_angular_reg;

    logic in_accept;
    logic out_free;

    logic signed [OPW-1:0]   mul_a;
    logic signed [OPW-1:0]   mul_b;
    logic signed [PRODW-1:0] prod;
    logic signed [PRODW-1:0] prod_abs;

    logic signed [OPW-1:0] sx;
    logic signed [OPW-1:0] sy;
    logic signed [OPW-1:0] st;
    logic signed [OPW-1:0] p0;
    logic signed [OPW-1:0] p1;
    logic signed [OPW-1:0] p2;
    logic signed [OPW-1:0] p3;

    logic [16:0] half_sum_eff;
    logic [9:0]  period_eff;

    logic signed [63:0] rot_sum;
    logic signed [63:0] rot_round;

    div_req_t           div_req;
    logic               div_done;
    logic signed [31:0] div_result;

    logic                  cordic_start;
    logic                  cordic_done;
    logic signed [OPW-1:0] cos_val;
    logic signed [OPW-1:0] sin_val;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    // A zero geometry or zero period is treated as one.
    assign half_sum_eff = (half_sum_reg == '0) ? 17'd1 : half_sum_reg;
    assign period_eff   = (period_ms_reg == '0) ? 10'd1 : period_ms_reg;

    assign p0 = {{(OPW-32){phi_reg[0][31]}}, phi_reg[0]};
    assign p1 = {{(OPW-32){phi_reg[1][31]}}, phi_reg[1]};
    assign p2 = {{(OPW-32){phi_reg[2][31]}}, phi_reg[2]};
    assign p3 = {{(OPW-32){phi_reg[3][31]}}, phi_reg[3]};
    assign sx = -p0 + p1 - p2 + p3;
    assign sy =  p0 + p1 + p2 + p3;
    assign st =  p0 - p1 - p2 + p3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_radius_reg <= 16'd3277;
            half_sum_reg     <= 17'd16876;
            rad_per_cnt_reg  <= 32'd3212628;
            period_ms_reg    <= 10'd50;
        end
        else if (cfg_write)
        begin
            priority case (cfg_index)
                REG_WHEEL_RADIUS: wheel_radius_reg <= cfg_data[15:0];
                REG_HALF_SUM:     half_sum_reg     <= cfg_data[16:0];
                REG_RAD_PER_CNT:  rad_per_cnt_reg  <= cfg_data;
                REG_PERIOD_MS:    period_ms_reg    <= cfg_data[9:0];
                default:          ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op_reg)
            OP_PHI0, OP_PHI1, OP_PHI2, OP_PHI3:
            begin
                mul_a = {{EXT{cnt_reg[op_reg[1:0]][COUNT_BITS-1]}}, cnt_reg[op_reg[1:0]]};
                mul_b = {2'b00, rad_per_cnt_reg};
            end
            OP_SX:
            begin
                mul_a = sx;
                mul_b = {18'd0, wheel_radius_reg};
            end
            OP_SY:
            begin
                mul_a = sy;
                mul_b = {18'd0, wheel_radius_reg};
            end
            OP_ST:
            begin
                mul_a = st;
                mul_b = {18'd0, wheel_radius_reg};
            end
            OP_DBIN:
            begin
                mul_a = {{(OPW-32){dth_reg[31]}}, dth_reg};
                mul_b = TURN_PER_RAD;
            end
            OP_ROT0:
            begin
                mul_a = {{(OPW-32){dxb_reg[31]}}, dxb_reg};
                mul_b = cos_val;
            end
            OP_ROT1:
            begin
                mul_a = {{(OPW-32){dyb_reg[31]}}, dyb_reg};
                mul_b = sin_val;
            end
            OP_ROT2:
            begin
                mul_a = {{(OPW-32){dxb_reg[31]}}, dxb_reg};
                mul_b = sin_val;
            end
            OP_ROT3:
            begin
                mul_a = {{(OPW-32){dyb_reg[31]}}, dyb_reg};
                mul_b = cos_val;
            end
            OP_VX:
            begin
                mul_a = {{(OPW-32){dxb_reg[31]}}, dxb_reg};
                mul_b = VEL_SCALE;
            end
            OP_VY:
            begin
                mul_a = {{(OPW-32){dyb_reg[31]}}, dyb_reg};
                mul_b = VEL_SCALE;
            end
            OP_VW:
            begin
                mul_a = {{(OPW-32){dth_reg[31]}}, dth_reg};
                mul_b = VEL_SCALE;
            end
            default: ;
        endcase
    end

    moi_mult u_mult (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign prod_abs = prod[PRODW-1] ? -prod : prod;

    always_comb
    begin
        div_req.start = (state_reg == ST_WB) &&
                        (op_reg == OP_ST || op_reg == OP_VX ||
                         op_reg == OP_VY || op_reg == OP_VW);
        div_req.neg   = prod[PRODW-1];
        div_req.mag   = prod_abs[63:0];
        div_req.den   = (op_reg == OP_ST) ? {half_sum_eff, 2'b00}
                                          : {{(DEN_W-10){1'b0}}, period_eff};
    end

    moi_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (div_req),
        .done   (div_done),
        .result (div_result)
    );

    assign cordic_start = (state_reg == ST_WB) && (op_reg == OP_DBIN);

    moi_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (pose_h_reg),
        .done    (cordic_done),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    assign rot_sum   = (op_reg == OP_ROT1) ? (acc_reg - prod[63:0]) : (acc_reg + prod[63:0]);
    assign rot_round = (rot_sum + (64'sd1 <<< 29)) >>> 30;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ISSUE;
                    op_next    = OP_PHI0;
                end
            end
            ST_ISSUE:
                state_next = ST_WB;
            ST_WB:
            begin
                if (op_reg == OP_ST || op_reg == OP_VX || op_reg == OP_VY ||
                    op_reg == OP_VW)
                    state_next = ST_DIV;
                else if (op_reg == OP_DBIN)
                    state_next = ST_CORDIC;
                else
                begin
                    state_next = ST_ISSUE;
                    op_next    = op_t'(op_reg + 4'd1);
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (op_reg == OP_VW)
                        state_next = ST_DONE;
                    else
                    begin
                        state_next = ST_ISSUE;
                        op_next    = (op_reg == OP_ST) ? OP_DBIN : op_t'(op_reg + 4'd1);
                    end
                end
            end
            ST_CORDIC:
            begin
                if (cordic_done)
                begin
                    state_next = ST_ISSUE;
                    op_next    = OP_ROT0;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_PHI0;
            out_valid_reg <= 1'b0;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            pose_h_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_WB && op_reg == OP_ROT1)
                pose_x_reg <= pose_x_reg + rot_round[31:0];
            if (state_reg == ST_WB && op_reg == OP_ROT3)
            begin
                pose_y_reg <= pose_y_reg + rot_round[31:0];
                pose_h_reg <= pose_h_reg + dbin_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cnt_reg[0] <= count_front_right;
            cnt_reg[1] <= count_front_left;
            cnt_reg[2] <= count_rear_left;
            cnt_reg[3] <= count_rear_right;
        end
        if (state_reg == ST_WB)
        begin
            unique case (op_reg)
                OP_PHI0, OP_PHI1, OP_PHI2, OP_PHI3:
                    phi_reg[op_reg[1:0]] <= sat32(rshift(prod, PHI_SH));
                OP_SX:   dxb_reg  <= sat32(rshift(prod, 18));
                OP_SY:   dyb_reg  <= sat32(rshift(prod, 18));
                OP_DBIN: dbin_reg <= 32'(rshift(prod, FRAC_BITS));
                OP_ROT0, OP_ROT2:
                    acc_reg <= prod[63:0];
                default: ;
            endcase
        end
        if (state_reg == ST_DIV && div_done)
        begin
            unique case (op_reg)
                OP_ST:   dth_reg <= div_result;
                OP_VX:   vx_reg  <= div_result;
                OP_VY:   vy_reg  <= div_result;
                OP_VW:   vw_reg  <= div_result;
                default: ;
            endcase
        end
        if (state_reg == ST_DONE && out_free)
        begin
            position_x_reg       <= pose_x_reg;
            position_y_reg       <= pose_y_reg;
            heading_angle_reg    <= pose_h_reg;
            velocity_x_reg       <= vx_reg;
            velocity_y_reg       <= vy_reg;
            velocity_angular_reg <= vw_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign position_x       = position_x_reg;
    assign position_y       = position_y_reg;
    assign heading_angle    = heading_angle_reg;
    assign velocity_x       = velocity_x_reg;
    assign velocity_y       = velocity_y_reg;
    assign velocity_angular = velocity_angular_reg;

`include "mecanum_odometry_integrator_top_assert.svh"

    `MOI_ASSERT_NOW(a_div_done_in_div, div_done, state_reg == ST_DIV, "divider done early")
    `MOI_ASSERT_NOW(a_cordic_done_in_wait, cordic_done, state_reg == ST_CORDIC, "CORDIC done early")
    `MOI_ASSERT_NEXT(a_accept_starts, in_accept, op_reg == OP_PHI0, "sequence not started")
    `MOI_ASSERT_NEXT(a_result_loaded, state_reg == ST_DONE && out_free, out_valid, "result lost")

endmodule

`default_nettype wire

// ===== tb/sv/mecanum_odometry_integrator_top_test.sv =====
`default_nettype none

module mecanum_odometry_integrator_top_test;
    import moi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] REG_NOT_MAPPED = 4'd9;
    localparam longint TURN_SCALE = 683565276;
    localparam longint ROTATOR_GAIN = 652032874;
    localparam int ROT_STEPS = 16;
    localparam int TURN_LIMIT = 30;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] heading;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_w;
    } odo_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [3:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] count_front_right;
    logic signed [15:0] count_front_left;
    logic signed [15:0] count_rear_left;
    logic signed [15:0] count_rear_right;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic [31:0]        heading_angle;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_angular;

    // Mirror of the block's registers and pose.
    logic [31:0] radius_q16;
    logic [31:0] half_sum_q16;
    logic [31:0] angle_per_count;
    logic [31:0] period_ms;
    logic [31:0] track_x;
    logic [31:0] track_y;
    logic [31:0] track_heading;

    odo_result_t pending_poses[$];
    int          mismatch_count;
    bit          idling_on;
    int          stall_left;

    longint rotator_atan[TURN_LIMIT] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    mecanum_odometry_integrator_top u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .count_front_right (count_front_right),
        .count_front_left  (count_front_left),
        .count_rear_left   (count_rear_left),
        .count_rear_right  (count_rear_right),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .position_x        (position_x),
        .position_y        (position_y),
        .heading_angle     (heading_angle),
        .velocity_x        (velocity_x),
        .velocity_y        (velocity_y),
        .velocity_angular  (velocity_angular)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_half_up(input longint v, input int s);
        longint half;
        half = longint'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic longint div_round_away(input longint n, input longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (2 * mag + d) / (2 * d);
        return (n < 0) ? -q : q;
    endfunction

    // Angles in the left half plane are turned by half a turn and the results negated.
    task automatic heading_cos_sin(input logic [31:0] ang, output longint c, output longint s);
        logic        flip;
        logic [31:0] a;
        longint      z;
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        a = flip ? ang + 32'h8000_0000 : ang;
        z = longint'(signed'(a));
        x = ROTATOR_GAIN;
        y = 0;
        for (int i = 0; i < ROT_STEPS && i < TURN_LIMIT; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - rotator_atan[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + rotator_atan[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic advance_pose(input logic signed [15:0] c1, input logic signed [15:0] c2,
                                input logic signed [15:0] c3, input logic signed [15:0] c4,
                                output odo_result_t r);
        longint      wa[4];
        longint      sum_x;
        longint      sum_y;
        longint      sum_t;
        longint      geom;
        longint      per;
        longint      dxb;
        longint      dyb;
        longint      dth;
        longint      cs;
        longint      sn;
        longint      dx;
        longint      dy;
        logic [31:0] dturn;
        wa[0] = clamp_s32(round_half_up(longint'(c1) * longint'(angle_per_count), 16));
        wa[1] = clamp_s32(round_half_up(longint'(c2) * longint'(angle_per_count), 16));
        wa[2] = clamp_s32(round_half_up(longint'(c3) * longint'(angle_per_count), 16));
        wa[3] = clamp_s32(round_half_up(longint'(c4) * longint'(angle_per_count), 16));
        sum_x = -wa[0] + wa[1] - wa[2] + wa[3];
        sum_y = wa[0] + wa[1] + wa[2] + wa[3];
        sum_t = wa[0] - wa[1] - wa[2] + wa[3];
        geom = (half_sum_q16 == 0) ? 1 : longint'(half_sum_q16);
        per = (period_ms == 0) ? 1 : longint'(period_ms);
        dxb = clamp_s32(round_half_up(sum_x * longint'(radius_q16), 18));
        dyb = clamp_s32(round_half_up(sum_y * longint'(radius_q16), 18));
        dth = clamp_s32(div_round_away(sum_t * longint'(radius_q16), 4 * geom));
        dturn = 32'(round_half_up(dth * TURN_SCALE, 16));
        heading_cos_sin(track_heading, cs, sn);
        dx = round_half_up(dxb * cs - dyb * sn, 30);
        dy = round_half_up(dxb * sn + dyb * cs, 30);
        track_x = track_x + 32'(dx);
        track_y = track_y + 32'(dy);
        track_heading = track_heading + dturn;
        r.pos_x = track_x;
        r.pos_y = track_y;
        r.heading = track_heading;
        r.vel_x = 32'(clamp_s32(div_round_away(dxb * 1000, per)));
        r.vel_y = 32'(clamp_s32(div_round_away(dyb * 1000, per)));
        r.vel_w = 32'(clamp_s32(div_round_away(dth * 1000, per)));
    endtask

    task automatic send_counts(input logic signed [15:0] c1, input logic signed [15:0] c2,
                               input logic signed [15:0] c3, input logic signed [15:0] c4);
        odo_result_t r;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        count_front_right = c1;
        count_front_left = c2;
        count_rear_left = c3;
        count_rear_right = c4;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        advance_pose(c1, c2, c3, c4, r);
        pending_poses.push_back(r);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_poses.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] value);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_WHEEL_RADIUS: radius_q16 = value & 32'hFFFF;
            REG_HALF_SUM:     half_sum_q16 = value & 32'h1FFFF;
            REG_RAD_PER_CNT:  angle_per_count = value;
            REG_PERIOD_MS:    period_ms = value & 32'h3FF;
            default:          ;
        endcase
    endtask

    // Upper bits above each register's width are filled with noise.
    task automatic set_geometry(input logic [31:0] wr, input logic [31:0] hs,
                                input logic [31:0] rpc, input logic [31:0] per);
        wait_drained();
        write_reg(REG_WHEEL_RADIUS, {16'($urandom_range(0, 65535)), wr[15:0]});
        write_reg(REG_HALF_SUM, {15'($urandom), hs[16:0]});
        write_reg(REG_RAD_PER_CNT, rpc);
        write_reg(REG_PERIOD_MS, {22'($urandom), per[9:0]});
    endtask

    function automatic logic signed [15:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return 16'sd0;
            1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2, 3, 4: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_counts(input int n);
        int mode;
        logic signed [15:0] base;
        for (int i = 0; i < n; i++)
        begin
            mode = $urandom_range(0, 4);
            base = pick_count();
            // Wheel patterns that move the body straight, sideways or in a spin, or random counts.
            case (mode)
                0: send_counts(base, base, base, base);
                1: send_counts(-base, base, -base, base);
                2: send_counts(base, -base, -base, base);
                default: send_counts(pick_count(), pick_count(), pick_count(), pick_count());
            endcase
        end
    endtask

    task automatic test_directed_extremes();
        send_counts(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_counts(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_counts(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_counts(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_counts(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
        send_counts(16'sd1, 16'sd1, 16'sd1, 16'sd1);
        send_counts(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
        for (int i = 0; i < 8; i++)
            send_counts(16'sd3000, -16'sd3000, -16'sd3000, 16'sd3000);
        send_counts(16'sd500, 16'sd500, 16'sd500, 16'sd500);
        send_counts(-16'sd500, 16'sd500, -16'sd500, 16'sd500);
    endtask

    task automatic test_register_extremes();
        set_geometry(32'd1, 32'd1, 32'd1, 32'd1);
        send_random_counts(12);
        set_geometry(32'd65535, 32'd131071, 32'hFFFF_FFFF, 32'd1000);
        send_random_counts(12);
        // A zero geometry sum and a zero period both act as one.
        set_geometry(32'd65535, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_counts(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
        send_random_counts(12);
        set_geometry(32'd3277, 32'd16876, 32'd3212628, 32'd1023);
        send_random_counts(12);
    endtask

    task automatic test_unmapped_register();
        wait_drained();
        write_reg(REG_NOT_MAPPED, 32'hFFFF_FFFF);
        write_reg(4'd15, 32'h0000_0000);
        send_random_counts(10);
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph[0])
                set_geometry($urandom_range(1, 65535), $urandom_range(1, 131071),
                             $urandom, $urandom_range(1, 1000));
            else
                set_geometry($urandom_range(1000, 8000), $urandom_range(8000, 40000),
                             $urandom_range(1000000, 8000000), $urandom_range(5, 100));
            send_random_counts(170);
        end
    endtask

    task automatic test_back_to_back();
        set_geometry(32'd3277, 32'd16876, 32'd3212628, 32'd50);
        idling_on = 1'b0;
        send_random_counts(250);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        odo_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_poses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction");
            end
            else
            begin
                want = pending_poses.pop_front();
                check_field("position_x", want.pos_x, position_x);
                check_field("position_y", want.pos_y, position_y);
                check_field("heading_angle", want.heading, heading_angle);
                check_field("velocity_x", want.vel_x, velocity_x);
                check_field("velocity_y", want.vel_y, velocity_y);
                check_field("velocity_angular", want.vel_w, velocity_angular);
            end
        end
    end

    // Result-side back-pressure in bursts, with quiet stretches between them.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 17);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int waited;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        count_front_right = '0;
        count_front_left = '0;
        count_rear_left = '0;
        count_rear_right = '0;
        out_stall = 1'b0;
        stall_left = 0;
        mismatch_count = 0;
        idling_on = 1'b1;
        radius_q16 = 32'd3277;
        half_sum_q16 = 32'd16876;
        angle_per_count = 32'd3212628;
        period_ms = 32'd50;
        track_x = '0;
        track_y = '0;
        track_heading = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_extremes();
        test_register_extremes();
        test_unmapped_register();
        test_random_settings();
        test_back_to_back();

        waited = 0;
        while (pending_poses.size() != 0 && waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (300) @(negedge clk);
        if (mismatch_count == 0 && pending_poses.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
